// ===== hw/rtl/ebc_pkg.sv =====
// ebc_pkg: shared types, constants and helpers of the encoder button event classifier
// no dependencies
package ebc_pkg;

	localparam int POSITION_BITS = 14;
	localparam int TICK_BITS     = 16;
	localparam int REFRESH_W     = 17;
	localparam int DELTA_W       = 14;
	localparam int CFG_W         = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int NUM_EVENTS    = 8;

	localparam logic [REFRESH_W-1:0] REFRESH_MAX = '1;

	// event codes, in the order they leave the block for one sample
	localparam logic [2:0] EV_UP       = 3'd0;
	localparam logic [2:0] EV_DOWN     = 3'd1;
	localparam logic [2:0] EV_SHORT    = 3'd2;
	localparam logic [2:0] EV_DOUBLE   = 3'd3;
	localparam logic [2:0] EV_LONG     = 3'd4;
	localparam logic [2:0] EV_ROT      = 3'd5;
	localparam logic [2:0] EV_ROT_HELD = 3'd6;
	localparam logic [2:0] EV_REFRESH  = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_SHORT_MAX  = 2'd0;
	localparam logic [1:0] CFG_LONG_MIN   = 2'd1;
	localparam logic [1:0] CFG_SAMPLE_MS  = 2'd2;
	localparam logic [1:0] CFG_REFRESH_MS = 2'd3;

	// button history codes
	localparam logic [1:0] BTN_RELEASED = 2'd0;
	localparam logic [1:0] BTN_PRESSED  = 2'd1;
	localparam logic [1:0] BTN_UNKNOWN  = 2'd3;

	typedef struct packed {
		logic [15:0] short_click_max;
		logic [15:0] long_click_min;
		logic [7:0]  sample_period_ms;
		logic [15:0] refresh_period_ms;
	} cfg_t;

	// all events of one sample: one mask bit per event code, plus the rotation delta
	typedef struct packed {
		logic [NUM_EVENTS-1:0]  mask;
		logic [DELTA_W-1:0]     delta;
	} bundle_t;

	// lowest set bit of an event mask, which is the next event to send
	function automatic logic [2:0] first_event(input logic [NUM_EVENTS-1:0] mask);
		logic [2:0] code;
		code = '0;
		for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				code = 3'(i);
			end
		end
		return code;
	endfunction

endpackage

// ===== hw/rtl/encoder_button_event_classifier.sv =====
// encoder_button_event_classifier: top level, configuration registers and assertions
// depends on ebc_pkg, ebc_front, ebc_queue, ebc_back
//
// One request on the input channel is one sample tick: the button level and the raw
// quadrature count. The front classifies it in the cycle it is taken and, if it causes
// any events, drops one bundle into a two-entry queue; the back then sends the events
// one per cycle while out_ready is high, through an output register, in order up, down,
// short, double, long, rotate, refresh, with last_event on the final one. A sample is
// taken whenever the queue has room, so samples may follow back to back; the sustained
// rate is set by the output port at one event per cycle while out_ready is high, a
// sample that causes events has one to five of them, and a sample with none produces
// nothing. Configuration writes are always taken (cfg_ready is tied high) and are
// meant to happen while the block is idle. No clearing pass is needed after reset.
module encoder_button_event_classifier
	import ebc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// sample channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      button_released,
	input  logic [15:0]               encoder_count,
	// event channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                event_code,
	output logic signed [DELTA_W-1:0] rotate_delta,
	output logic                      last_event,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	cfg_t    cfg_q;
	logic    q_push;
	logic    q_ready;
	logic    q_pop;
	logic    q_valid;
	bundle_t push_data;
	bundle_t pop_data;

	// registers are plain flops, so a write is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_click_max   <= 16'd30;
			cfg_q.long_click_min    <= 16'd100;
			cfg_q.sample_period_ms  <= 8'd10;
			cfg_q.refresh_period_ms <= 16'd500;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHORT_MAX:  cfg_q.short_click_max   <= cfg_data;
				CFG_LONG_MIN:   cfg_q.long_click_min    <= cfg_data;
				CFG_SAMPLE_MS:  cfg_q.sample_period_ms  <= cfg_data[7:0];
				CFG_REFRESH_MS: cfg_q.refresh_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: history and classification, one sample per cycle while the queue has room
	ebc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.button_released (button_released),
		.encoder_count   (encoder_count),
		.q_ready         (q_ready),
		.q_push          (q_push),
		.q_data          (push_data)
	);

	// decouples classification from the output stalls
	ebc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	// back: serialises each bundle into single events
	ebc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_code   (event_code),
		.rotate_delta (rotate_delta),
		.last_event   (last_event)
	);

	// the front never pushes a bundle the queue cannot hold
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> q_ready)
		else $error("bundle pushed into a full queue");

	// only rotate events carry a delta
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(event_code == EV_ROT || event_code == EV_ROT_HELD)
			|-> rotate_delta == '0)
		else $error("delta on a non-rotate event");

	// a rotate event always carries a nonzero delta
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == EV_ROT || event_code == EV_ROT_HELD)
			|-> rotate_delta != '0)
		else $error("rotate event with zero delta");

	// a refresh event is always the last one of its sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_REFRESH |-> last_event)
		else $error("refresh event not last");

endmodule

// ===== hw/rtl/ebc_front.sv =====
// ebc_front: takes samples, keeps button and position history, classifies events
// depends on ebc_pkg
module ebc_front
	import ebc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                button_released,
	input  logic [15:0]         encoder_count,
	input  logic                q_ready,
	output logic                q_push,
	output bundle_t             q_data
);

	logic [1:0]               button_prev_q;
	logic [TICK_BITS-1:0]     edge_ticks_q;
	logic [1:0]               click_run_q;
	logic [POSITION_BITS-1:0] last_position_q;
	logic [REFRESH_W-1:0]     refresh_elapsed_q;

	logic [1:0]               prev_n;
	logic [TICK_BITS-1:0]     ticks_n;
	logic [TICK_BITS-1:0]     ticks_next;
	logic [1:0]               run_n;
	logic [1:0]               run_inc;
	logic [REFRESH_W-1:0]     elapsed_n;
	logic [REFRESH_W:0]       elapsed_sum;
	logic [REFRESH_W-1:0]     elapsed_next;
	logic [31:0]              count_shift;
	logic [POSITION_BITS-1:0] pos;
	logic [POSITION_BITS-1:0] diff;
	logic [NUM_EVENTS-1:0]    mask;
	logic                     short_hold;
	logic                     long_hold;
	logic                     accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	assign run_inc     = (click_run_q == 2'd3) ? 2'd3 : click_run_q + 2'd1;
	assign short_hold  = 32'(edge_ticks_q) <= 32'(cfg.short_click_max);
	assign long_hold   = 32'(edge_ticks_q) >= 32'(cfg.long_click_min);
	assign count_shift = 32'(encoder_count) >> 2;
	assign pos         = count_shift[POSITION_BITS-1:0];
	assign diff        = pos - last_position_q;

	always_comb begin
		mask      = '0;
		prev_n    = button_prev_q;
		ticks_n   = edge_ticks_q;
		run_n     = click_run_q;
		elapsed_n = refresh_elapsed_q;

		// button edges
		if (button_released) begin
			if (button_prev_q != BTN_RELEASED) begin
				mask[EV_UP] = 1'b1;
				prev_n      = BTN_RELEASED;
				elapsed_n   = '0;
				if (short_hold) begin
					mask[EV_SHORT] = 1'b1;
					if (run_inc == 2'd3) begin
						mask[EV_DOUBLE] = 1'b1;
						run_n           = 2'd0;
					end else begin
						run_n = run_inc;
					end
				end else if (long_hold) begin
					mask[EV_LONG] = 1'b1;
					run_n         = 2'd0;
				end
				ticks_n = '0;
			end
		end else begin
			if (button_prev_q != BTN_PRESSED) begin
				mask[EV_DOWN] = 1'b1;
				prev_n        = BTN_PRESSED;
				elapsed_n     = '0;
				run_n         = short_hold ? run_inc : 2'd0;
				ticks_n       = '0;
			end
		end

		// rotation
		if (diff != '0) begin
			if (prev_n == BTN_PRESSED) begin
				mask[EV_ROT_HELD] = 1'b1;
			end else begin
				mask[EV_ROT] = 1'b1;
			end
			elapsed_n = '0;
		end

		// refresh
		if (cfg.refresh_period_ms != '0
				&& 32'(elapsed_n) >= 32'(cfg.refresh_period_ms)) begin
			mask[EV_REFRESH] = 1'b1;
			elapsed_n        = elapsed_n - REFRESH_W'(cfg.refresh_period_ms);
		end
	end

	assign elapsed_sum  = {1'b0, elapsed_n} + (REFRESH_W + 1)'(cfg.sample_period_ms);
	assign elapsed_next = elapsed_sum[REFRESH_W] ? REFRESH_MAX : elapsed_sum[REFRESH_W-1:0];
	assign ticks_next   = (32'(ticks_n) <= 32'(cfg.long_click_min) && ticks_n != '1)
		? ticks_n + 1'b1 : ticks_n;

	assign q_push       = accept && (mask != '0);
	assign q_data.mask  = mask;
	assign q_data.delta = DELTA_W'($signed(diff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_prev_q     <= BTN_UNKNOWN;
			edge_ticks_q      <= '0;
			click_run_q       <= '0;
			last_position_q   <= '0;
			refresh_elapsed_q <= '0;
		end else if (accept) begin
			button_prev_q     <= prev_n;
			edge_ticks_q      <= ticks_next;
			click_run_q       <= run_n;
			last_position_q   <= pos;
			refresh_elapsed_q <= elapsed_next;
		end
	end

endmodule

// ===== hw/rtl/ebc_queue.sv =====
// ebc_queue: short first-in first-out queue of event bundles between front and back
// depends on ebc_pkg
module ebc_queue
	import ebc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    ready,
	input  logic    pop,
	output logic    valid,
	output bundle_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bundle_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign ready    = count_q != CNT_W'(QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ebc_back.sv =====
// ebc_back: sends the events of each bundle one per cycle while out_ready is high, through an output register
// depends on ebc_pkg
module ebc_back
	import ebc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  bundle_t                    q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 event_code,
	output logic signed [DELTA_W-1:0]  rotate_delta,
	output logic                       last_event
);

	logic [NUM_EVENTS-1:0] pend_mask_q;
	logic [DELTA_W-1:0]    pend_delta_q;
	logic                  out_valid_q;
	logic [2:0]            code_q;
	logic [DELTA_W-1:0]    delta_q;
	logic                  last_q;

	logic                  load;
	logic                  have_pend;
	logic                  have;
	logic [NUM_EVENTS-1:0] src_mask;
	logic [DELTA_W-1:0]    src_delta;
	logic [NUM_EVENTS-1:0] rest;
	logic [2:0]            code;
	logic                  is_rot;

	assign load      = !out_valid_q || out_ready;
	assign have_pend = pend_mask_q != '0;
	assign have      = have_pend || q_valid;
	assign q_pop     = load && !have_pend && q_valid;
	assign src_mask  = have_pend ? pend_mask_q : q_data.mask;
	assign src_delta = have_pend ? pend_delta_q : q_data.delta;
	assign rest      = src_mask & (src_mask - 1'b1);
	assign code      = first_event(src_mask);
	assign is_rot    = (code == EV_ROT) || (code == EV_ROT_HELD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_mask_q <= '0;
		end else if (load) begin
			out_valid_q <= have;
			if (have) begin
				pend_mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			code_q       <= code;
			delta_q      <= is_rot ? src_delta : '0;
			last_q       <= rest == '0;
			pend_delta_q <= src_delta;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = code_q;
	assign rotate_delta = $signed(delta_q);
	assign last_event   = last_q;

endmodule

// ===== tb/tb_encoder_button_event_classifier.sv =====
`timescale 1ns / 1ps
// tb_encoder_button_event_classifier: self-checking testbench of the encoder button event classifier
// depends on ebc_pkg and encoder_button_event_classifier; an event predictor is kept in a small class

module tb_encoder_button_event_classifier;
	import ebc_pkg::*;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS  = 320;
	localparam int PHASE_ITEMS   = 55;
	localparam int LONG_HOLD     = 60;
	localparam int POS_MASK      = (1 << POSITION_BITS) - 1;
	localparam int TICK_LIMIT    = (1 << TICK_BITS) - 1;

	// one predicted event as it should leave the block
	typedef struct packed {
		logic [2:0]         code;
		logic [DELTA_W-1:0] delta;
		logic               last;
	} event_rec_t;

	// event predictor and store of expected events
	class ebc_scoreboard;
		cfg_t        cfg;
		logic [1:0]  btn_hist;
		int unsigned hold_ticks;
		int unsigned click_run;
		int unsigned last_pos;
		int unsigned quiet_ms;
		event_rec_t  expected_q[$];
		int          errors;

		function new();
			cfg.short_click_max   = 16'd30;
			cfg.long_click_min    = 16'd100;
			cfg.sample_period_ms  = 8'd10;
			cfg.refresh_period_ms = 16'd500;
			btn_hist   = BTN_UNKNOWN;
			hold_ticks = 0;
			click_run  = 0;
			last_pos   = 0;
			quiet_ms   = 0;
			errors     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_SHORT_MAX:  cfg.short_click_max   = data;
				CFG_LONG_MIN:   cfg.long_click_min    = data;
				CFG_SAMPLE_MS:  cfg.sample_period_ms  = data[7:0];
				CFG_REFRESH_MS: cfg.refresh_period_ms = data;
				default: ;
			endcase
		endfunction

		// work out every event of one accepted sample and queue them in order
		function void note_sample(logic released, logic [15:0] count);
			event_rec_t  evs[$];
			event_rec_t  ev;
			int unsigned pos;
			int unsigned diff;
			ev = '0;
			if (released) begin
				if (btn_hist != BTN_RELEASED) begin
					ev.code = EV_UP;
					evs.push_back(ev);
					btn_hist = BTN_RELEASED;
					quiet_ms = 0;
					if (hold_ticks <= cfg.short_click_max) begin
						ev.code = EV_SHORT;
						evs.push_back(ev);
						click_run = (click_run >= 3) ? 3 : click_run + 1;
						if (click_run >= 3) begin
							ev.code = EV_DOUBLE;
							evs.push_back(ev);
							click_run = 0;
						end
					end else if (hold_ticks >= cfg.long_click_min) begin
						ev.code = EV_LONG;
						evs.push_back(ev);
						click_run = 0;
					end
					hold_ticks = 0;
				end
			end else begin
				if (btn_hist != BTN_PRESSED) begin
					ev.code = EV_DOWN;
					evs.push_back(ev);
					btn_hist = BTN_PRESSED;
					quiet_ms = 0;
					if (hold_ticks <= cfg.short_click_max) begin
						click_run = (click_run >= 3) ? 3 : click_run + 1;
					end else begin
						click_run = 0;
					end
					hold_ticks = 0;
				end
			end

			pos = (int'(count) >> 2) & POS_MASK;
			diff = (pos - last_pos) & POS_MASK;
			last_pos = pos;
			if (diff != 0) begin
				ev.code  = (btn_hist == BTN_PRESSED) ? EV_ROT_HELD : EV_ROT;
				ev.delta = diff[DELTA_W-1:0];
				evs.push_back(ev);
				ev.delta = '0;
				quiet_ms = 0;
			end

			if (cfg.refresh_period_ms != 0 && quiet_ms >= cfg.refresh_period_ms) begin
				ev.code = EV_REFRESH;
				evs.push_back(ev);
				quiet_ms -= cfg.refresh_period_ms;
			end

			quiet_ms += cfg.sample_period_ms;
			if (quiet_ms > int'(REFRESH_MAX)) begin
				quiet_ms = int'(REFRESH_MAX);
			end
			if (hold_ticks <= cfg.long_click_min && hold_ticks < TICK_LIMIT) begin
				hold_ticks++;
			end

			if (evs.size() > 0) begin
				evs[evs.size() - 1].last = 1'b1;
			end
			foreach (evs[i]) begin
				expected_q.push_back(evs[i]);
			end
		endfunction

		function void check_event(logic [2:0] code, logic [DELTA_W-1:0] delta, logic last);
			event_rec_t exp_ev;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected event code %0d delta %0d last %0d",
					$time, code, $signed(delta), last);
				errors++;
				return;
			end
			exp_ev = expected_q.pop_front();
			if (code !== exp_ev.code) begin
				$display("%0t: event_code expected %0d got %0d", $time, exp_ev.code, code);
				errors++;
			end
			if (delta !== exp_ev.delta) begin
				$display("%0t: rotate_delta expected %0d got %0d", $time,
					$signed(exp_ev.delta), $signed(delta));
				errors++;
			end
			if (last !== exp_ev.last) begin
				$display("%0t: last_event expected %0d got %0d", $time, exp_ev.last, last);
				errors++;
			end
		endfunction
	endclass

	// every block input known from time zero
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      button_released = 1'b1;
	logic [15:0]               encoder_count = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [2:0]                event_code;
	logic signed [DELTA_W-1:0] rotate_delta;
	logic                      last_event;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [1:0]                cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;

	ebc_scoreboard sb;
	int            cycle_count = 0;
	int            samples_sent = 0;
	int            rx_hold = 0;
	bit            tx_quiet = 1'b0;
	bit            rx_quiet = 1'b0;
	int            cur_short = 30;
	int            cur_long = 100;
	logic [15:0]   enc_now = '0;

	encoder_button_event_classifier uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.button_released (button_released),
		.encoder_count   (encoder_count),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_code      (event_code),
		.rotate_delta    (rotate_delta),
		.last_event      (last_event),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL encoder_button_event_classifier");
			$finish;
		end
	end

	// gap length: one draw in ten is a long gap, the others are short
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// hold length aimed at the short, middle and long bands of the current thresholds
	function automatic int pick_hold();
		int n;
		case ($urandom_range(0, 3))
			0: n = $urandom_range(0, cur_short);
			1: n = $urandom_range(cur_short + 1,
				(cur_long > cur_short + 1) ? cur_long - 1 : cur_short + 1);
			2: n = $urandom_range(cur_long, cur_long + 3);
			default: n = $urandom_range(1, 3);
		endcase
		return (n < 1) ? 1 : n;
	endfunction

	// encoder mostly still, sometimes a few detents, rarely a jump anywhere
	function automatic logic [15:0] next_count();
		case ($urandom_range(0, 9))
			6, 7: enc_now = enc_now + 16'($urandom_range(0, 24)) - 16'd12;
			8: enc_now = enc_now + 16'($urandom_range(0, 3));
			9: enc_now = 16'($urandom);
			default: ;
		endcase
		return enc_now;
	endfunction

	// receiver: random stalls at every phase of the output stream, none in quiet stretches
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			rx_hold = pick_gap() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: config writes and sample requests feed the predictor, events are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				sb.note_sample(button_released, encoder_count);
			end
			if (out_valid && out_ready) begin
				sb.check_event(event_code, rotate_delta, last_event);
			end
		end
	end

	// one sample request; valid stays high afterwards so requests can follow back to back
	task automatic send_sample(input logic rel, input logic [15:0] cnt);
		int gap;
		gap = tx_quiet ? 0 : (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		button_released <= rel;
		encoder_count   <= cnt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// all four registers, written only while the block is idle
	task automatic set_config(input int s, input int l, input int sp, input int rp);
		cfg_write(CFG_SHORT_MAX, CFG_W'(s));
		cfg_write(CFG_LONG_MIN, CFG_W'(l));
		cfg_write(CFG_SAMPLE_MS, CFG_W'(sp));
		cfg_write(CFG_REFRESH_MS, CFG_W'(rp));
		@(negedge clk) cfg_valid <= 1'b0;
		cur_short = s;
		cur_long  = l;
	endtask

	// stop sending and let every expected event come out, then let the block settle
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a press held for p ticks, then a release held for r ticks, encoder wandering
	task automatic click_seq(input int p, input int r);
		repeat (p) send_sample(1'b0, next_count());
		repeat (r) send_sample(1'b1, next_count());
	endtask

	initial begin
		int base;
		int phase_start;
		int sp;
		int rp;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset thresholds: first sample, click run to a double, rotation extremes
		send_sample(1'b1, 16'h0000);   // first sample released: up and short
		send_sample(1'b1, 16'h0003);   // same detent, nothing
		send_sample(1'b1, 16'h0004);   // +1
		send_sample(1'b0, 16'h0004);   // down, run grows
		send_sample(1'b1, 16'h0004);   // up, short, third in a row gives double
		send_sample(1'b1, 16'hFFFF);   // wraps to -2
		send_sample(1'b0, 16'h0000);   // down and held rotate +1
		send_sample(1'b0, 16'h8000);   // most negative delta
		send_sample(1'b0, 16'h7FFF);   // -1
		send_sample(1'b0, 16'h0000);   // -8191
		send_sample(1'b0, 16'h7FFC);   // most positive delta
		send_sample(1'b1, 16'hAAAA);
		send_sample(1'b0, 16'h5555);
		drain();

		// tight thresholds, zero sample period: middle-length and long holds
		set_config(1, 4, 0, 1);
		send_sample(1'b1, 16'h5555);
		repeat (3) send_sample(1'b0, 16'h5555);
		send_sample(1'b1, 16'h5555);   // middle hold: up only
		repeat (5) send_sample(1'b0, 16'h5554);
		send_sample(1'b1, 16'h5554);   // long click
		send_sample(1'b0, 16'h5554);   // down after a short release
		send_sample(1'b1, 16'h5554);
		drain();

		// refresh off, widest sample period: hold tick counter stops past the long threshold
		set_config(2, 40, 255, 0);
		tx_quiet = 1'b1;
		repeat (LONG_HOLD) send_sample(1'b0, 16'h1230);
		send_sample(1'b1, 16'h1230);   // long click after a hold well past the threshold
		tx_quiet = 1'b0;
		drain();

		// random phases, each with its own register setting
		base = samples_sent;
		for (int ph = 0; samples_sent - base < RANDOM_ITEMS; ph++) begin
			drain();
			if (ph == 0) begin
				// refresh period below the sample period
				set_config(0, 0, 255, 1);
			end else if (ph == 1) begin
				set_config(30, 100, 10, 500);
			end else begin
				case ($urandom_range(0, 2))
					0: sp = 1;
					1: sp = 255;
					default: sp = $urandom_range(1, 255);
				endcase
				case ($urandom_range(0, 3))
					0: rp = 0;
					1: rp = 65535;
					2: rp = $urandom_range(1, 60);
					default: rp = $urandom_range(100, 3000);
				endcase
				set_config($urandom_range(0, 6), $urandom_range(0, 14), sp, rp);
			end
			// one stretch with no idling on either side
			tx_quiet = (ph == 2);
			rx_quiet = (ph == 2);
			phase_start = samples_sent;
			while (samples_sent - phase_start < PHASE_ITEMS
				&& samples_sent - base < RANDOM_ITEMS) begin
				case ($urandom_range(0, 11))
					0, 1: begin
						// noise: random levels and random counts
						repeat ($urandom_range(1, 6)) send_sample(1'($urandom), 16'($urandom));
					end
					2: drain();   // sender holds off until the block has emptied
					default: click_seq(pick_hold(), pick_hold());
				endcase
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		drain();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS encoder_button_event_classifier");
		end else begin
			if (sb.pending() != 0) begin
				$display("%0t: %0d expected events never arrived", $time, sb.pending());
			end
			$display("FAIL encoder_button_event_classifier");
		end
		$finish;
	end

endmodule
